[rtl/core/sseq_pkg.sv]
package sseq_pkg;

  // Default coordinate width (point and vertex magnitude bits)
  localparam int COORD_BITS_DEF = 16;

  // Field widths fixed by the interface
  localparam int IN_W    = 16;
  localparam int BRUSH_W = 12;
  localparam int PRESS_W = 16;
  localparam int COLOR_W = 32;
  localparam int Q_W     = 13;   // rounded offset magnitude bits
  localparam int OFF_W   = Q_W + 1;

  // Register reset values
  localparam logic [BRUSH_W-1:0] BRUSH_RESET  = 12'd80;
  localparam logic [COLOR_W-1:0] COLOUR_RESET = 32'hFF0000FF;

  // Pen commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Register indexes
  localparam logic REG_BRUSH  = 1'b0;
  localparam logic REG_COLOUR = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic       cap_start;   // record a stroke start point
    logic       cap_end;     // record the new end point
    logic       diff;        // form dx, dy magnitudes
    logic       square;      // square the magnitudes
    logic       root_init;   // load the square-root unit
    logic       root_step;   // one square-root iteration
    logic       den;         // form the divisor
    logic       mul1;        // magnitude times brush
    logic       mul2;        // times pressure, load divider
    logic       div_step;    // one quotient bit
    logic       store_off;   // write signed offset
    logic       load_out;    // load output vertex
    logic       commit;      // end point becomes previous point
    logic [1:0] sel;         // offset or vertex select
  } dp_cmd_t;

endpackage

[rtl/core/sseq_ctrl.sv]
module sseq_ctrl #(
  parameter int COORD_BITS = sseq_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_command,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sseq_pkg::dp_cmd_t cmd
);

  localparam int W    = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int RW   = W + 8;
  localparam int CNTW = $clog2(RW);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DIFF   = 11'b00000000010,
    S_SQUARE = 11'b00000000100,
    S_RINIT  = 11'b00000001000,
    S_ROOT   = 11'b00000010000,
    S_DEN    = 11'b00000100000,
    S_MUL1   = 11'b00001000000,
    S_MUL2   = 11'b00010000000,
    S_DIV    = 11'b00100000000,
    S_STORE  = 11'b01000000000,
    S_SEND   = 11'b10000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            drawing_r, drawing_nxt;
  logic            load_r, load_nxt;   // output vertex load pending in SEND
  logic            acc;

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid & in_tready;
  assign out_tvalid = (state_r == S_SEND) & ~load_r;

  // Sequence one request through the datapath
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    drawing_nxt = drawing_r;
    load_nxt    = 1'b0;
    cmd         = '0;
    cmd.sel     = k_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_command == sseq_pkg::CMD_BEGIN) begin
            cmd.cap_start = 1'b1;
            drawing_nxt   = 1'b1;
          end else if (in_command == sseq_pkg::CMD_END) begin
            drawing_nxt = 1'b0;
          end else if (in_command == sseq_pkg::CMD_ADD && drawing_r) begin
            cmd.cap_end = 1'b1;
            state_nxt   = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_RINIT;
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = CNTW'(RW - 1);
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        k_nxt     = 2'd0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = CNTW'(sseq_pkg::Q_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store_off = 1'b1;
        k_nxt         = k_r + 1'b1;
        if (k_r == 2'd3) begin
          state_nxt = S_SEND;
          load_nxt  = 1'b1;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_SEND: begin
        if (load_r) begin
          cmd.load_out = 1'b1;
        end else if (out_tready) begin
          k_nxt = k_r + 1'b1;
          if (k_r == 2'd3) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            load_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      k_r       <= '0;
      drawing_r <= 1'b0;
      load_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      k_r       <= k_nxt;
      drawing_r <= drawing_nxt;
      load_r    <= load_nxt;
    end
  end

endmodule

[rtl/core/sseq_datapath.sv]
module sseq_datapath #(
  parameter int COORD_BITS = sseq_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sseq_pkg::dp_cmd_t            cmd,
  input  logic [sseq_pkg::IN_W-1:0]    in_x,
  input  logic [sseq_pkg::IN_W-1:0]    in_y,
  input  logic [sseq_pkg::PRESS_W-1:0] in_p,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sseq_pkg::COLOR_W-1:0] cfg_data,
  output logic [COORD_BITS:0]          vtx_x,
  output logic [COORD_BITS:0]          vtx_y,
  output logic [sseq_pkg::COLOR_W-1:0] vtx_colour,
  output logic [1:0]                   vtx_index,
  output logic                         vtx_last
);

  localparam int C    = COORD_BITS;
  localparam int W    = (C < 16) ? C : 16;     // used point bits
  localparam int RW   = W + 8;                 // root bits
  localparam int VW   = 2 * RW;                // radicand bits
  localparam int M1W  = W + sseq_pkg::BRUSH_W;
  localparam int PW   = M1W + sseq_pkg::PRESS_W;
  localparam int DENW = RW + 16;
  localparam int RNW  = DENW + sseq_pkg::Q_W - 1;
  localparam int SW   = ((C > 14) ? C : 14) + 3;
  localparam int OW   = sseq_pkg::OFF_W;

  // Configuration registers
  logic [sseq_pkg::BRUSH_W-1:0] brush_r;
  logic [sseq_pkg::COLOR_W-1:0] colour_r;

  // Stroke points
  logic [W-1:0]                 x0_r, y0_r, x1_r, y1_r;
  logic [sseq_pkg::PRESS_W-1:0] p0_r, p1_r;
  logic [sseq_pkg::COLOR_W-1:0] c0_r, c1_r;

  // Working registers
  logic [W-1:0]      mx_r, my_r;
  logic              dxn_r, dyn_r;
  logic [2*W-1:0]    sqx_r, sqy_r;
  logic [VW-1:0]     v_r, rt_r, bit_r;
  logic [DENW-1:0]   den_r;
  logic [M1W-1:0]    m1_r;
  logic [RNW-1:0]    rem_r, dv_r;
  logic [sseq_pkg::Q_W-1:0] q_r;
  logic [OW-1:0]     off_r [4];

  logic [W:0]        dx_s, dy_s;
  logic [VW:0]       trial;
  logic [RW-1:0]     lenq;
  logic [W-1:0]      mag;
  logic [sseq_pkg::PRESS_W-1:0] psel;
  logic [PW-1:0]     prod;
  logic              neg;
  logic [OW-1:0]     qs;

  assign dx_s = {1'b0, x1_r} - {1'b0, x0_r};
  assign dy_s = {1'b0, y1_r} - {1'b0, y0_r};
  assign trial = {1'b0, v_r} - ({1'b0, rt_r} + {1'b0, bit_r});
  assign lenq  = rt_r[RW-1:0];
  assign mag   = cmd.sel[0] ? mx_r : my_r;
  assign psel  = cmd.sel[1] ? p1_r : p0_r;
  assign prod  = m1_r * psel;
  // x offset is -dy, y offset is +dx
  assign neg   = cmd.sel[0] ? dxn_r : ~dyn_r;
  assign qs    = neg ? (OW'(0) - {1'b0, q_r}) : {1'b0, q_r};

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_r  <= sseq_pkg::BRUSH_RESET;
      colour_r <= sseq_pkg::COLOUR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sseq_pkg::REG_BRUSH) brush_r <= cfg_data[sseq_pkg::BRUSH_W-1:0];
      else colour_r <= cfg_data;
    end
  end

  // Hold previous point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      y0_r <= '0;
      p0_r <= '0;
      c0_r <= '0;
    end else if (cmd.cap_start) begin
      x0_r <= in_x[W-1:0];
      y0_r <= in_y[W-1:0];
      p0_r <= in_p;
      c0_r <= colour_r;
    end else if (cmd.commit) begin
      x0_r <= x1_r;
      y0_r <= y1_r;
      p0_r <= p1_r;
      c0_r <= c1_r;
    end
  end

  // Offset arithmetic
  always_ff @(posedge clk) begin
    if (cmd.cap_end) begin
      x1_r <= in_x[W-1:0];
      y1_r <= in_y[W-1:0];
      p1_r <= in_p;
      c1_r <= colour_r;
    end
    if (cmd.diff) begin
      dxn_r <= dx_s[W];
      dyn_r <= dy_s[W];
      mx_r  <= dx_s[W] ? W'(~dx_s + 1'b1) : dx_s[W-1:0];
      my_r  <= dy_s[W] ? W'(~dy_s + 1'b1) : dy_s[W-1:0];
    end
    if (cmd.square) begin
      sqx_r <= mx_r * mx_r;
      sqy_r <= my_r * my_r;
    end
    // bit-serial integer square root of len2 * 2^14
    if (cmd.root_init) begin
      v_r   <= VW'({({1'b0, sqx_r} + {1'b0, sqy_r}), 14'b0});
      rt_r  <= '0;
      bit_r <= VW'(1) << (VW - 2);
    end
    if (cmd.root_step) begin
      if (!trial[VW]) begin
        v_r  <= trial[VW-1:0];
        rt_r <= (rt_r >> 1) + bit_r;
      end else begin
        rt_r <= rt_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.den) den_r <= {lenq, 16'b0} - DENW'(lenq);
    if (cmd.mul1) m1_r <= mag * brush_r;
    // numerator with half divisor for rounding
    if (cmd.mul2) begin
      rem_r <= RNW'({prod, 7'b0}) + RNW'(den_r >> 1);
      dv_r  <= RNW'(den_r) << (sseq_pkg::Q_W - 1);
      q_r   <= '0;
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[sseq_pkg::Q_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[sseq_pkg::Q_W-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
    // zero-length segment gets a zero normal
    if (cmd.store_off) off_r[cmd.sel] <= (lenq == '0) ? '0 : qs;
  end

  // Vertex build and saturation
  logic [W-1:0]          px, py;
  logic [OW-1:0]         ox, oy;
  logic signed [SW-1:0]  sx, sy, ex, ey;
  logic [C:0]            satx, saty;

  assign px = cmd.sel[1] ? x1_r : x0_r;
  assign py = cmd.sel[1] ? y1_r : y0_r;
  assign ox = cmd.sel[1] ? off_r[2] : off_r[0];
  assign oy = cmd.sel[1] ? off_r[3] : off_r[1];
  assign ex = $signed({{(SW-OW){ox[OW-1]}}, ox});
  assign ey = $signed({{(SW-OW){oy[OW-1]}}, oy});
  assign sx = cmd.sel[0] ? $signed({{(SW-W){1'b0}}, px}) - ex
                         : $signed({{(SW-W){1'b0}}, px}) + ex;
  assign sy = cmd.sel[0] ? $signed({{(SW-W){1'b0}}, py}) - ey
                         : $signed({{(SW-W){1'b0}}, py}) + ey;

  always_comb begin
    if (sx[SW-1:C] == {(SW-C){sx[C]}}) satx = sx[C:0];
    else if (sx[SW-1]) satx = {1'b1, {C{1'b0}}};
    else satx = {1'b0, {C{1'b1}}};
    if (sy[SW-1:C] == {(SW-C){sy[C]}}) saty = sy[C:0];
    else if (sy[SW-1]) saty = {1'b1, {C{1'b0}}};
    else saty = {1'b0, {C{1'b1}}};
  end

  // Load output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      vtx_x      <= satx;
      vtx_y      <= saty;
      vtx_colour <= cmd.sel[1] ? c1_r : c0_r;
      vtx_index  <= cmd.sel;
      vtx_last   <= (cmd.sel == 2'd3);
    end
  end

endmodule

[rtl/core/stroke_segment_quad_extruder.sv]
// Channel | Group  | Fields (low bit up)
// input   | in_    | tuser: command; tdata: pos_x, pos_y, pen_pressure
// output  | out_   | tuser: vertex_index; tlast: last_vertex;
//         |        | tdata: vertex_x, vertex_y, vertex_colour, zero pad
// config  | cfg_   | index 0 brush_half_width, 1 pen_colour
// An add point runs, in order: set-up (difference, square, square-root
// load), COORD_BITS'+8 square-root steps (COORD_BITS' = min(COORD_BITS,
// 16)), the divisor step, 4 offsets (two multiplies, 13 quotient steps,
// store) and the send of four vertices, each loaded into the output
// register and then offered. Begin, end and ignored requests are handled
// in the idle state. No request is taken while vertices are pending.
// Reset is synchronous; it clears the stroke state and restores registers.
module stroke_segment_quad_extruder #(
  parameter int COORD_BITS = sseq_pkg::COORD_BITS_DEF,
  localparam int DATAW = ((2 * COORD_BITS + 34 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // pos_x, pos_y, pen_pressure
  input  logic [1:0]       in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [DATAW-1:0] out_tdata,  // vertex_x, vertex_y, vertex_colour
  output logic [1:0]       out_tuser,  // vertex_index
  output logic             out_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);

  sseq_pkg::dp_cmd_t cmd;
  logic [COORD_BITS:0] vx, vy;
  logic [31:0]         vcol;

  sseq_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sseq_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_x       (in_tdata[15:0]),
    .in_y       (in_tdata[31:16]),
    .in_p       (in_tdata[47:32]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vtx_x      (vx),
    .vtx_y      (vy),
    .vtx_colour (vcol),
    .vtx_index  (out_tuser),
    .vtx_last   (out_tlast)
  );

  // Pack the vertex
  assign out_tdata = DATAW'({vcol, vy, vx});

endmodule

[rtl/core/sseq_checker.sv]
module sseq_checker #(
  parameter int COORD_BITS = sseq_pkg::COORD_BITS_DEF,
  localparam int DATAW = ((2 * COORD_BITS + 34 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [47:0]      in_tdata,
  input logic [1:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [DATAW-1:0] out_tdata,
  input logic [1:0]       out_tuser,
  input logic             out_tlast,
  input logic             cfg_we,
  input logic             cfg_index,
  input logic [31:0]      cfg_data
);

  // Last flag marks the fourth vertex only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 2'd3)))
    else $error("last flag does not match vertex index");

  // Stalled vertex holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled vertex changed");

  // No new request while a vertex is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while vertices pending");

  // Vertices of a segment follow in index order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid ##1 (out_tvalid && out_tuser == $past(out_tuser, 2) + 2'd1))
    else $error("vertex order broken");

endmodule

bind stroke_segment_quad_extruder sseq_checker #(.COORD_BITS(COORD_BITS)) u_sseq_checker (.*);
